### rtl/core/fhd_pkg.sv
// package with shared types and constants of the frame header deframer
`timescale 1ns / 1ps
package fhd_pkg;

  localparam int unsigned HDR_BYTES = 32;
  localparam int unsigned HDR_CNT_W = $clog2(HDR_BYTES);
  localparam int unsigned STORE_DEPTH = HDR_BYTES - 1;
  localparam int unsigned LEN_W = 16;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = '1;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_BODY    = 2'd1,
    KIND_LAST    = 2'd2,
    KIND_LEN_ERR = 2'd3
  } kind_e;

  // one registered input item
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } stage_t;

  // one result item
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        version;
    logic [15:0]       mission_id;
    logic [31:0]       source_id;
    logic [31:0]       dest_id;
    logic [31:0]       class_id;
    logic [31:0]       sequence_res;
    logic [7:0]        flags;
    logic [31:0]       spare;
    logic [47:0]       date_time;
    logic [LEN_W-1:0]  total_length;
    logic [7:0]        body_byte;
  } res_t;

endpackage

### rtl/core/fhd_byte_if.sv
// byte stream channel of the deframer
`timescale 1ns / 1ps
interface fhd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

### rtl/core/fhd_res_if.sv
// result channel of the deframer
`timescale 1ns / 1ps
interface fhd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  version;
  logic [15:0] mission_id;
  logic [31:0] source_id;
  logic [31:0] dest_id;
  logic [31:0] class_id;
  logic [31:0] sequence_res;
  logic [7:0]  flags;
  logic [31:0] spare;
  logic [47:0] date_time;
  logic [15:0] total_length;
  logic [7:0]  body_byte;

  modport source (
    output valid, input ready, output kind, output version, output mission_id,
    output source_id, output dest_id, output class_id, output sequence_res,
    output flags, output spare, output date_time, output total_length,
    output body_byte
  );
  modport sink (
    input valid, output ready, input kind, input version, input mission_id,
    input source_id, input dest_id, input class_id, input sequence_res,
    input flags, input spare, input date_time, input total_length,
    input body_byte
  );
endinterface

### rtl/core/fhd_cfg_if.sv
// configuration write channel of the deframer
`timescale 1ns / 1ps
interface fhd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] wdata;

  modport source (output valid, output wdata, input ready);
  modport sink (input valid, input wdata, output ready);
endinterface

### rtl/core/fhd_in_stage.sv
// input register stage of the deframer
`timescale 1ns / 1ps
module fhd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [7:0]      data_i,
  input  logic            advance_i,
  output logic            ready_o,
  output fhd_pkg::stage_t stage_o
);
  import fhd_pkg::*;

  logic       vld_q, vld_d;
  logic [7:0] data_q;
  logic       take;

  assign ready_o = !vld_q || advance_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_i;
    end
  end

  assign stage_o.vld  = vld_q;
  assign stage_o.data = data_q;

endmodule

### rtl/core/fhd_core.sv
// framing state, header shift line and header decode
`timescale 1ns / 1ps
module fhd_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [fhd_pkg::LEN_W-1:0] cfg_data_i,
  input  fhd_pkg::stage_t          stage_i,
  input  logic                     advance_i,
  output logic                     res_vld_o,
  output fhd_pkg::res_t            res_o
);
  import fhd_pkg::*;

  logic                 phase_q, phase_d;
  logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [LEN_W-1:0]     body_rem_q, body_rem_d;
  logic [LEN_W-1:0]     max_len_q;
  logic [7:0]           hdr_q [STORE_DEPTH];
  logic                 fire;
  logic                 shift_en;
  logic                 last_hdr;
  logic [LEN_W-1:0]     total;
  logic [LEN_W-1:0]     rem;
  logic                 len_bad;
  logic [7:0]           b;

  assign fire     = stage_i.vld && advance_i;
  assign b        = stage_i.data;
  assign last_hdr = (hdr_cnt_q == HDR_CNT_W'(HDR_BYTES - 1));
  assign shift_en = fire && !phase_q && !last_hdr;
  assign total    = {hdr_q[STORE_DEPTH-1], b};
  assign rem      = total - LEN_W'(HDR_BYTES);
  assign len_bad  = (total > max_len_q) || (total < LEN_W'(HDR_BYTES));

  // next state
  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    body_rem_d = body_rem_q;
    if (fire) begin
      if (phase_q) begin
        if (body_rem_q <= LEN_W'(1)) begin
          body_rem_d = '0;
          phase_d    = 1'b0;
        end else begin
          body_rem_d = body_rem_q - LEN_W'(1);
        end
      end else if (!last_hdr) begin
        hdr_cnt_d = hdr_cnt_q + HDR_CNT_W'(1);
      end else begin
        hdr_cnt_d = '0;
        if (len_bad) begin
          body_rem_d = '0;
          phase_d    = 1'b0;
        end else begin
          body_rem_d = rem;
          phase_d    = (rem != '0);
        end
      end
    end
  end

  // result
  always_comb begin
    res_vld_o = fire && (phase_q || last_hdr);
    res_o     = '0;
    if (phase_q) begin
      res_o.kind      = (body_rem_q <= LEN_W'(1)) ? KIND_LAST : KIND_BODY;
      res_o.body_byte = b;
    end else begin
      res_o.kind         = len_bad ? KIND_LEN_ERR : KIND_HEADER;
      res_o.version      = hdr_q[0];
      res_o.mission_id   = {hdr_q[1], hdr_q[2]};
      res_o.source_id    = {hdr_q[3], hdr_q[4], hdr_q[5], hdr_q[6]};
      res_o.dest_id      = {hdr_q[7], hdr_q[8], hdr_q[9], hdr_q[10]};
      res_o.class_id     = {hdr_q[11], hdr_q[12], hdr_q[13], hdr_q[14]};
      res_o.sequence_res = {hdr_q[15], hdr_q[16], hdr_q[17], hdr_q[18]};
      res_o.flags        = hdr_q[19];
      res_o.spare        = {hdr_q[20], hdr_q[21], hdr_q[22], hdr_q[23]};
      res_o.date_time    = {hdr_q[24], hdr_q[25], hdr_q[26], hdr_q[27],
                            hdr_q[28], hdr_q[29]};
      res_o.total_length = total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 1'b0;
      hdr_cnt_q  <= '0;
      body_rem_q <= '0;
      max_len_q  <= MAX_LEN_RESET;
    end else begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      body_rem_q <= body_rem_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  // header bytes shift toward entry 0, oldest byte ends there
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < STORE_DEPTH - 1; i++) begin
        hdr_q[i] <= hdr_q[i+1];
      end
      hdr_q[STORE_DEPTH-1] <= b;
    end
  end

`ifndef SYNTH
  a_cnt_only_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_cnt_q != '0) |-> !phase_q)
    else $error("header count running while in body");

  a_body_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (body_rem_q != '0))
    else $error("in body with no bytes left");

  a_last_ends_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && phase_q && (body_rem_q == LEN_W'(1))) |=> (!phase_q && hdr_cnt_q == '0))
    else $error("last body byte did not return to hunting");
`endif

endmodule

### rtl/core/fhd_out_stage.sv
// result register stage of the deframer
`timescale 1ns / 1ps
module fhd_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_vld_i,
  input  fhd_pkg::res_t res_i,
  input  logic          ready_i,
  output logic          advance_o,
  output logic          valid_o,
  output fhd_pkg::res_t res_o
);
  import fhd_pkg::*;

  logic vld_q, vld_d;
  res_t res_q;

  assign advance_o = !vld_q || ready_i;
  assign vld_d     = advance_o ? res_vld_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

### rtl/core/frame_header_deframer.sv
// top level of the length-prefixed frame header deframer
// usage:
// - in_i carries the received byte stream, one byte per item
// - the first 32 bytes form a big-endian header; on the 32nd byte one header
//   item (kind 0) comes out with all decoded fields
// - then each body byte comes out as kind 1, the final one as kind 2
// - a total length above max_total_length or below 32 gives one kind 3 item
//   with the decoded fields, and hunting restarts at the next byte
// - a header of exactly 32 bytes gives only the header item
// - cfg_i writes max_total_length, always ready; write it only while idle
// timing:
// - latency is 1 cycle: a byte taken into the input register at one edge is
//   decoded in that cycle and its result is valid on res_o after the next edge
// - throughput is one byte per cycle, every step is one counter and a byte shift
// - when res_o stalls, the input register holds its byte and in_i.ready drops
//   until the result is taken; an empty input register takes one byte first
// reset:
// - rst_ni clears both stages, hunting restarts at header byte 0 and the
//   maximum length returns to 65535
`timescale 1ns / 1ps
module frame_header_deframer (
  input  logic   clk_i,
  input  logic   rst_ni,
  fhd_cfg_if.sink  cfg_i,
  fhd_byte_if.sink in_i,
  fhd_res_if.source res_o
);
  import fhd_pkg::*;

  stage_t stage;
  logic   advance;
  logic   res_vld;
  res_t   res_next;
  res_t   res_out;

  // config register is a plain write, nothing to wait for
  assign cfg_i.ready = 1'b1;

  // input register, refills while the result register drains
  fhd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .data_i    (in_i.data_byte),
    .advance_i (advance),
    .ready_o   (in_i.ready),
    .stage_o   (stage)
  );

  // framing state and header decode, one byte per advance
  fhd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.wdata),
    .stage_i    (stage),
    .advance_i  (advance),
    .res_vld_o  (res_vld),
    .res_o      (res_next)
  );

  // result register, holds its item while the receiver stalls
  fhd_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_vld_i (res_vld),
    .res_i     (res_next),
    .ready_i   (res_o.ready),
    .advance_o (advance),
    .valid_o   (res_o.valid),
    .res_o     (res_out)
  );

  // unpack onto the result channel
  assign res_o.kind         = res_out.kind;
  assign res_o.version      = res_out.version;
  assign res_o.mission_id   = res_out.mission_id;
  assign res_o.source_id    = res_out.source_id;
  assign res_o.dest_id      = res_out.dest_id;
  assign res_o.class_id     = res_out.class_id;
  assign res_o.sequence_res = res_out.sequence_res;
  assign res_o.flags        = res_out.flags;
  assign res_o.spare        = res_out.spare;
  assign res_o.date_time    = res_out.date_time;
  assign res_o.total_length = res_out.total_length;
  assign res_o.body_byte    = res_out.body_byte;

endmodule
